FILE: src/priority_task_scheduler_with_sleep_assert.svh
// assertion macros for the priority task scheduler checker
// expects signals named clock and reset in the scope of each use
`ifndef PRIORITY_TASK_SCHEDULER_WITH_SLEEP_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_SLEEP_ASSERT_SVH

// same-cycle implication
`define PTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication
`define PTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

FILE: src/pts_pkg.sv
// shared types and constants for the priority task scheduler
// no dependencies; used by every module of the block
package pts_pkg;

   localparam int TASK_BITS = 5;
   localparam int MAP_BITS  = 32;
   localparam int WAKE_BITS = 24;
   localparam int TIME_BITS = 24;

   // request operation codes
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SLEEP = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_DONE
   } st_type;

   typedef struct packed {
      op_type                 op;
      logic [TASK_BITS-1:0]   task_priority;
      logic [TIME_BITS-1:0]   sleep_duration;
      logic [TIME_BITS-1:0]   elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [TASK_BITS-1:0]   running_task;
      logic                   idle_selected;
      logic [WAKE_BITS-1:0]   next_wake;
      logic [MAP_BITS-1:0]    ready_tasks;
   } rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                   apply;
      logic                   age;
      logic                   sleep;
      logic                   add;
      logic [TASK_BITS-1:0]   target;
   } cell_ctrl_type;

   // partial result handed along the cell chain
   typedef struct packed {
      logic                   blocked_found;
      logic                   ready_found;
      logic [TASK_BITS-1:0]   best_prio;
   } scan_flags_type;

endpackage

FILE: src/pts_cell.sv
// one task cell: ready and blocked bits, sleep counter and one scan stage
// depends on pts_pkg
module pts_cell import pts_pkg::*; #(
   parameter int COUNT_BITS = 24,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [COUNT_BITS-1:0] elapsed,
   input  logic [COUNT_BITS-1:0] dur,
   input  scan_flags_type        flags_in,
   input  logic [COUNT_BITS-1:0] min_in,
   output scan_flags_type        flags_out,
   output logic [COUNT_BITS-1:0] min_out,
   output logic                  ready
);

   logic                  ready_ff, ready_in;
   logic                  blocked_ff, blocked_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   scan_flags_type        flags_ff, flags_in_next;
   logic [COUNT_BITS-1:0] min_ff, min_in_next;
   logic                  hit;
   logic                  expired;

   // task state update on the apply cycle
   always_comb begin
      hit        = (ctrl.target == TASK_BITS'(INDEX));
      expired    = (count_ff <= elapsed);
      ready_in   = ready_ff;
      blocked_in = blocked_ff;
      count_in   = count_ff;
      if (ctrl.apply) begin
         if (ctrl.age && blocked_ff) begin
            if (expired) begin
               blocked_in = 1'b0;
               ready_in   = 1'b1;
            end else begin
               count_in = count_ff - elapsed;
            end
         end
         // new sleeper keeps its full duration
         if (ctrl.sleep && hit) begin
            ready_in   = 1'b0;
            blocked_in = 1'b1;
            count_in   = dur;
         end
         if (ctrl.add && hit) begin
            ready_in = 1'b1;
         end
      end
   end

   // fold this cell into the running minimum and highest ready priority
   always_comb begin
      flags_in_next = flags_in;
      min_in_next   = min_in;
      if (blocked_ff && (!flags_in.blocked_found || (count_ff < min_in))) begin
         flags_in_next.blocked_found = 1'b1;
         min_in_next                 = count_ff;
      end
      if (ready_ff) begin
         flags_in_next.ready_found = 1'b1;
         flags_in_next.best_prio   = TASK_BITS'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff   <= 1'b0;
         blocked_ff <= 1'b0;
         flags_ff   <= '0;
      end else begin
         ready_ff   <= ready_in;
         blocked_ff <= blocked_in;
         flags_ff   <= flags_in_next;
      end
   end

   // counter and scan minimum carry no reset
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      min_ff   <= min_in_next;
   end

   assign flags_out = flags_ff;
   assign min_out   = min_ff;
   assign ready     = ready_ff;

endmodule

FILE: src/priority_task_scheduler_with_sleep.sv
// top level of the priority task scheduler with sleep timers
// depends on pts_pkg and pts_cell
//
// Usage:
//   request channel (req_valid, req_stall, req_payload) carries add, sleep,
//   tick and no-op requests; result channel (rsp_valid, rsp_stall,
//   rsp_payload) returns exactly one result per request: running task,
//   idle flag, next wake interval and the ready bitmap.
//   A request passes from acceptance to a valid result through an apply step
//   that updates every cell at once, then the minimum and priority scan
//   down the chain of task cells, one register per cell, then the register
//   of the result.
//   One request is in flight at a time: the next request is accepted only
//   after the previous result has been loaded into the output register.
//   req_stall is high while a request is being worked on. When rsp_stall
//   holds a result, the next request can still be accepted and worked on;
//   its result waits in the last stage until the output register frees.
//   Synchronous reset clears the ready and blocked maps, selects the idle
//   task and empties the output; sleep counters are written before use.
module priority_task_scheduler_with_sleep import pts_pkg::*; #(
   parameter int NUM_TASKS  = 32,
   parameter int COUNT_BITS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(NUM_TASKS);

   st_type                 state_ff, state_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   cell_ctrl_type          ctrl_ff, ctrl_in, cell_ctrl;
   logic [COUNT_BITS-1:0]  elapsed_ff, dur_ff;
   logic [COUNT_BITS-1:0]  elapsed_cb, dur_cb;
   logic [TASK_BITS-1:0]   current_task_ff, new_task;
   logic                   current_idle_ff, new_idle;
   logic                   rsp_valid_ff;
   rsp_type                rsp_payload_ff, rsp_next;
   logic                   req_accept;
   logic                   load_rsp;
   logic [WAKE_BITS-1:0]   wake;
   logic [NUM_TASKS-1:0]   ready_vec;
   scan_flags_type         flags_link [0:NUM_TASKS];
   logic [COUNT_BITS-1:0]  min_link   [0:NUM_TASKS];

   assign req_accept = req_valid && !req_stall;
   assign elapsed_cb = COUNT_BITS'(req_payload.elapsed_ms);
   assign dur_cb     = COUNT_BITS'(req_payload.sleep_duration);

   // decode the request into a cell command
   always_comb begin
      ctrl_in        = '0;
      ctrl_in.target = req_payload.task_priority;
      unique case (req_payload.op)
         OP_ADD: begin
            ctrl_in.add = 1'b1;
         end
         OP_SLEEP: begin
            // ignored while idle runs or for a zero duration
            if (!current_idle_ff && (dur_cb != '0)) begin
               ctrl_in.sleep  = 1'b1;
               ctrl_in.age    = 1'b1;
               ctrl_in.target = current_task_ff;
            end
         end
         OP_TICK: begin
            ctrl_in.age = 1'b1;
         end
         OP_NOP: begin
            ctrl_in = ctrl_in;
         end
         default: begin
            ctrl_in = '0;
         end
      endcase
   end

   // sequencer: next state and handshake outputs
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      req_stall   = 1'b1;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            scan_cnt_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_cnt_ff == CNT_W'(NUM_TASKS - 1)) begin
               state_in = ST_DONE;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (req_accept) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         elapsed_ff <= elapsed_cb;
         dur_ff     <= dur_cb;
      end
   end

   // cells act only on the apply cycle
   always_comb begin
      cell_ctrl       = ctrl_ff;
      cell_ctrl.apply = (state_ff == ST_APPLY);
   end

   // chain of task cells
   assign flags_link[0] = '0;
   assign min_link[0]   = '0;

   for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
      pts_cell #(
         .COUNT_BITS (COUNT_BITS),
         .INDEX      (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .elapsed   (elapsed_ff),
         .dur       (dur_ff),
         .flags_in  (flags_link[g]),
         .min_in    (min_link[g]),
         .flags_out (flags_link[g+1]),
         .min_out   (min_link[g+1]),
         .ready     (ready_vec[g])
      );
   end

   // result from the end of the chain
   always_comb begin
      new_task = current_task_ff;
      new_idle = current_idle_ff;
      if (ctrl_ff.age) begin
         new_idle = !flags_link[NUM_TASKS].ready_found;
         new_task = flags_link[NUM_TASKS].ready_found ?
                    flags_link[NUM_TASKS].best_prio : '0;
      end
      // saturate wide counters to the output width
      if (!flags_link[NUM_TASKS].blocked_found) begin
         wake = '0;
      end else if ((COUNT_BITS > WAKE_BITS) &&
                   ((min_link[NUM_TASKS] >> WAKE_BITS) != '0)) begin
         wake = '1;
      end else begin
         wake = WAKE_BITS'(min_link[NUM_TASKS]);
      end
      rsp_next.running_task  = new_idle ? '0 : new_task;
      rsp_next.idle_selected = new_idle;
      rsp_next.next_wake     = wake;
      rsp_next.ready_tasks   = MAP_BITS'(ready_vec);
   end

   // running task and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         current_task_ff <= '0;
         current_idle_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else if (load_rsp) begin
         current_task_ff <= new_task;
         current_idle_ff <= new_idle;
         rsp_valid_ff    <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: src/pts_checker.sv
// port-level checks for the priority task scheduler, bound to the top level
// depends on pts_pkg and priority_task_scheduler_with_sleep_assert.svh
`include "priority_task_scheduler_with_sleep_assert.svh"

module pts_checker import pts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // idle result reports task zero
   `PTS_ASSERT_NOW(a_idle_task_zero, rsp_valid && rsp_payload.idle_selected, rsp_payload.running_task == '0)

   // the running task is always marked ready
   `PTS_ASSERT_NOW(a_running_is_ready, rsp_valid && !rsp_payload.idle_selected, rsp_payload.ready_tasks[rsp_payload.running_task])

   // one request at a time: stall follows every accepted request
   `PTS_ASSERT_NEXT(a_busy_after_request, req_valid && !req_stall, req_stall)

   // held result stays put
   `PTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind priority_task_scheduler_with_sleep pts_checker u_pts_checker (.*);
